// ----- rtl/lrtd_pkg.sv -----
// Package for the lens radial/tangential distortion unit.
// Holds register indexes, intermediate limits and rounding/saturation helpers.
// No dependencies.
`timescale 1ns / 1ps

package lrtd_pkg;

  localparam int IN_W  = 18;
  localparam int OUT_W = 20;
  localparam int MID_W = 32;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_K1 = 3'd0;
  localparam logic [IDX_W-1:0] REG_K2 = 3'd1;
  localparam logic [IDX_W-1:0] REG_P1 = 3'd2;
  localparam logic [IDX_W-1:0] REG_P2 = 3'd3;

  localparam logic signed [63:0] MID_MAX = 64'sd2147483647;
  localparam logic signed [63:0] MID_MIN = -64'sd2147483647;
  localparam logic signed [63:0] OUT_MAX = 64'sd524287;
  localparam logic signed [63:0] OUT_MIN = -64'sd524288;

  typedef struct packed {
    logic                    hit;
    logic signed [OUT_W-1:0] val;
  } sat_t;

  // round half up to f fraction bits
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input logic [4:0] f);
    rnd = (v + (64'sd1 <<< (f - 5'd1))) >>> f;
  endfunction

  // clamp an intermediate to +-(2^31 - 1)
  function automatic logic signed [MID_W-1:0] mid(input logic signed [63:0] v);
    if (v > MID_MAX) begin
      mid = MID_W'(MID_MAX);
    end else if (v < MID_MIN) begin
      mid = MID_W'(MID_MIN);
    end else begin
      mid = MID_W'(v);
    end
  endfunction

  function automatic sat_t sat_out(input logic signed [63:0] v);
    sat_t s;
    if (v > OUT_MAX) begin
      s.hit = 1'b1;
      s.val = OUT_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      s.hit = 1'b1;
      s.val = OUT_W'(OUT_MIN);
    end else begin
      s.hit = 1'b0;
      s.val = OUT_W'(v);
    end
    return s;
  endfunction

endpackage

// ----- rtl/lens_radial_tangential_distortion_unit.sv -----
// Top level of the lens radial/tangential distortion unit (k1, k2, p1, p2).
// Nine-stage pipeline from a normalized point to a saturated distorted point.
// Depends on lrtd_pkg.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | in_norm_x, in_norm_y                    | start high, busy low
//  result  | out_dist_x, out_dist_y, out_clipped     | out_valid strobe, 1 cycle
//  config  | cfg_idx, cfg_data                       | cfg_we high, no wait
//
// One item is taken every cycle while busy is low; its result passes the nine registered
// stages and is shown on the result ports with the out_valid strobe.
// The depth is set by the multiplier chain r2 -> r4 -> k2*r4 -> radial factor -> x*rad.
// Synchronous active-low reset clears the coefficients and the valid bits; busy is
// high in the cycle after reset and low afterwards.
// The receiver cannot stall: every result is shown for exactly one cycle.
`timescale 1ns / 1ps

module lens_radial_tangential_distortion_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [lrtd_pkg::IN_W-1:0]    in_norm_x,
  input  logic signed [lrtd_pkg::IN_W-1:0]    in_norm_y,
  input  logic                                cfg_we,
  input  logic        [lrtd_pkg::IDX_W-1:0]   cfg_idx,
  input  logic        [lrtd_pkg::IN_W-1:0]    cfg_data,
  output logic                                out_valid,
  output logic signed [lrtd_pkg::OUT_W-1:0]   out_dist_x,
  output logic signed [lrtd_pkg::OUT_W-1:0]   out_dist_y,
  output logic                                out_clipped
);

  localparam int          IW  = lrtd_pkg::IN_W;
  localparam int          MW  = lrtd_pkg::MID_W;
  localparam int          OW  = lrtd_pkg::OUT_W;
  localparam int          NST = 8;
  localparam logic [4:0]  FB  = 5'(FRAC_BITS);
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

  logic busy_r;
  logic in_acc;
  logic [NST-1:0] vld_r;

  logic signed [IW-1:0] k1_r, k2_r, p1_r, p2_r;

  // stage 1: input
  logic signed [IW-1:0] x1_r, y1_r;
  // stage 2: squares and cross product
  logic signed [2*IW-1:0] xx2_r, yy2_r, xy2_r, xx_nxt, yy_nxt, xy_nxt;
  logic signed [IW-1:0]   x2_r, y2_r;
  // stage 3: rounded intermediates
  logic signed [MW-1:0] r2_3_r, xsq3_r, ysq3_r, pxy3_r;
  logic signed [IW-1:0] x3_r, y3_r;
  // stage 4
  logic signed [63:0]   r4p4_r, r4p_nxt;
  logic signed [49:0]   k1p4_r, k1p_nxt;
  logic signed [MW+1:0] sx4_r, sy4_r, sx_nxt, sy_nxt;
  logic signed [MW-1:0] pxy4_r;
  logic signed [IW-1:0] x4_r, y4_r;
  // stage 5
  logic signed [MW-1:0] r4_5_r;
  logic signed [63:0]   k1t5_r;
  logic signed [MW:0]   pxy2_4;
  logic signed [50:0]   ptx1_nxt, pty2_nxt;
  logic signed [51:0]   ptx2_nxt, pty1_nxt;
  logic signed [50:0]   ptx1_5_r, pty2_5_r;
  logic signed [51:0]   ptx2_5_r, pty1_5_r;
  logic signed [IW-1:0] x5_r, y5_r;
  // stage 6
  logic signed [49:0]   k2p6_r, k2p_nxt;
  logic signed [63:0]   k1t6_r, tanx6_r, tany6_r;
  logic signed [IW-1:0] x6_r, y6_r;
  // stage 7
  logic signed [MW-1:0] rad7_r;
  logic signed [63:0]   tanx7_r, tany7_r;
  logic signed [IW-1:0] x7_r, y7_r;
  // stage 8
  logic signed [49:0]   mx8_r, my8_r, mx_nxt, my_nxt;
  logic signed [63:0]   tanx8_r, tany8_r;
  // output
  logic                 out_valid_r, out_clipped_r;
  logic signed [OW-1:0] out_dist_x_r, out_dist_y_r;
  lrtd_pkg::sat_t       satx, saty;

  assign busy   = busy_r;
  assign in_acc = start && !busy_r;

  assign xx_nxt = x1_r * x1_r;
  assign yy_nxt = y1_r * y1_r;
  assign xy_nxt = x1_r * y1_r;

  assign r4p_nxt = 64'(r2_3_r) * 64'(r2_3_r);
  assign k1p_nxt = k1_r * r2_3_r;
  assign sx_nxt  = (MW+2)'(r2_3_r) + ((MW+2)'(xsq3_r) <<< 1);
  assign sy_nxt  = (MW+2)'(r2_3_r) + ((MW+2)'(ysq3_r) <<< 1);

  assign pxy2_4   = (MW+1)'(pxy4_r) <<< 1;
  assign ptx1_nxt = p1_r * pxy2_4;
  assign pty2_nxt = p2_r * pxy2_4;
  assign ptx2_nxt = p2_r * sx4_r;
  assign pty1_nxt = p1_r * sy4_r;

  assign k2p_nxt = k2_r * r4_5_r;

  assign mx_nxt = x7_r * rad7_r;
  assign my_nxt = y7_r * rad7_r;

  assign satx = lrtd_pkg::sat_out(lrtd_pkg::rnd(64'(mx8_r), FB) + tanx8_r);
  assign saty = lrtd_pkg::sat_out(lrtd_pkg::rnd(64'(my8_r), FB) + tany8_r);

  // control: reset, valid bits, coefficients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      k1_r        <= '0;
      k2_r        <= '0;
      p1_r        <= '0;
      p2_r        <= '0;
    end else begin
      busy_r      <= 1'b0;
      vld_r       <= {vld_r[NST-2:0], in_acc};
      out_valid_r <= vld_r[NST-1];
      if (cfg_we) begin
        case (cfg_idx)
          lrtd_pkg::REG_K1: k1_r <= cfg_data;
          lrtd_pkg::REG_K2: k2_r <= cfg_data;
          lrtd_pkg::REG_P1: p1_r <= cfg_data;
          lrtd_pkg::REG_P2: p2_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath: advance every cycle
  always_ff @(posedge clk) begin
    x1_r <= in_norm_x;
    y1_r <= in_norm_y;

    xx2_r <= xx_nxt;
    yy2_r <= yy_nxt;
    xy2_r <= xy_nxt;
    x2_r  <= x1_r;
    y2_r  <= y1_r;

    r2_3_r <= lrtd_pkg::mid(lrtd_pkg::rnd(64'(xx2_r) + 64'(yy2_r), FB));
    xsq3_r <= lrtd_pkg::mid(lrtd_pkg::rnd(64'(xx2_r), FB));
    ysq3_r <= lrtd_pkg::mid(lrtd_pkg::rnd(64'(yy2_r), FB));
    pxy3_r <= lrtd_pkg::mid(lrtd_pkg::rnd(64'(xy2_r), FB));
    x3_r   <= x2_r;
    y3_r   <= y2_r;

    r4p4_r <= r4p_nxt;
    k1p4_r <= k1p_nxt;
    sx4_r  <= sx_nxt;
    sy4_r  <= sy_nxt;
    pxy4_r <= pxy3_r;
    x4_r   <= x3_r;
    y4_r   <= y3_r;

    r4_5_r   <= lrtd_pkg::mid(lrtd_pkg::rnd(r4p4_r, FB));
    k1t5_r   <= lrtd_pkg::rnd(64'(k1p4_r), FB);
    ptx1_5_r <= ptx1_nxt;
    ptx2_5_r <= ptx2_nxt;
    pty1_5_r <= pty1_nxt;
    pty2_5_r <= pty2_nxt;
    x5_r     <= x4_r;
    y5_r     <= y4_r;

    k2p6_r  <= k2p_nxt;
    k1t6_r  <= k1t5_r;
    tanx6_r <= lrtd_pkg::rnd(64'(ptx1_5_r), FB) + lrtd_pkg::rnd(64'(ptx2_5_r), FB);
    tany6_r <= lrtd_pkg::rnd(64'(pty1_5_r), FB) + lrtd_pkg::rnd(64'(pty2_5_r), FB);
    x6_r    <= x5_r;
    y6_r    <= y5_r;

    rad7_r  <= lrtd_pkg::mid(ONE + k1t6_r + lrtd_pkg::rnd(64'(k2p6_r), FB));
    tanx7_r <= tanx6_r;
    tany7_r <= tany6_r;
    x7_r    <= x6_r;
    y7_r    <= y6_r;

    mx8_r   <= mx_nxt;
    my8_r   <= my_nxt;
    tanx8_r <= tanx7_r;
    tany8_r <= tany7_r;

    out_dist_x_r  <= satx.val;
    out_dist_y_r  <= saty.val;
    out_clipped_r <= satx.hit || saty.hit;
  end

  assign out_valid   = out_valid_r;
  assign out_dist_x  = out_dist_x_r;
  assign out_dist_y  = out_dist_y_r;
  assign out_clipped = out_clipped_r;

  a_out_follows_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(vld_r[NST-1])))
    else $error("result strobe not matched to last pipeline stage");

  a_r2_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> !r2_3_r[MW-1])
    else $error("r2 negative");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_dist_x == OW'(lrtd_pkg::OUT_MAX) || out_dist_x == OW'(lrtd_pkg::OUT_MIN) ||
       out_dist_y == OW'(lrtd_pkg::OUT_MAX) || out_dist_y == OW'(lrtd_pkg::OUT_MIN)))
    else $error("clip flag set with no output at a limit");

  a_busy_released: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy held after reset");

endmodule

// ----- tb/tb_lens_radial_tangential_distortion_unit.sv -----
// Self-checking bench for the lens radial/tangential distortion unit.
// Drives points in bursts under several coefficient sets and checks each result
// against a bit-accurate fixed-point predictor. Depends on lrtd_pkg and the unit.
`timescale 1ns / 1ps

module tb_lens_radial_tangential_distortion_unit;

  localparam int     IN_W        = lrtd_pkg::IN_W;
  localparam int     OUT_W       = lrtd_pkg::OUT_W;
  localparam int     IDX_W       = lrtd_pkg::IDX_W;
  localparam int     FRAC        = 16;
  localparam int     DRAIN       = 16;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     PRINT_LIMIT = 40;
  localparam longint MID_LIM     = 64'sd2147483647;
  localparam longint OUT_HI      = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint OUT_LO      = -(longint'(1) <<< (OUT_W - 1));
  localparam int     Q_HI        = (1 <<< (IN_W - 1)) - 1;
  localparam int     Q_LO        = -(1 <<< (IN_W - 1));
  localparam int     Q_ONE       = 1 <<< FRAC;

  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] dx;
    logic signed [OUT_W-1:0] dy;
    logic                    clip;
  } distorted_t;

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    start       = 1'b0;
  logic                    busy;
  logic signed [IN_W-1:0]  in_norm_x   = '0;
  logic signed [IN_W-1:0]  in_norm_y   = '0;
  logic                    cfg_we      = 1'b0;
  logic        [IDX_W-1:0] cfg_idx     = '0;
  logic        [IN_W-1:0]  cfg_data    = '0;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_dist_x;
  logic signed [OUT_W-1:0] out_dist_y;
  logic                    out_clipped;

  logic signed [IN_W-1:0]  coef_k1 = '0;
  logic signed [IN_W-1:0]  coef_k2 = '0;
  logic signed [IN_W-1:0]  coef_p1 = '0;
  logic signed [IN_W-1:0]  coef_p2 = '0;

  point_t      pending_points[$];
  distorted_t  expected_points[$];
  point_t      next_point;
  distorted_t  oldest_point;
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;

  lens_radial_tangential_distortion_unit #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_norm_x  (in_norm_x),
    .in_norm_y  (in_norm_y),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_dist_x (out_dist_x),
    .out_dist_y (out_dist_y),
    .out_clipped(out_clipped)
  );

  always #6 clk = ~clk;

  function automatic longint round_q(input longint v);
    return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint clamp_mid(input longint v);
    if (v > MID_LIM) return MID_LIM;
    if (v < -MID_LIM) return -MID_LIM;
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(input longint v, inout logic hit);
    if (v > OUT_HI) begin
      hit = 1'b1;
      return OUT_W'(OUT_HI);
    end
    if (v < OUT_LO) begin
      hit = 1'b1;
      return OUT_W'(OUT_LO);
    end
    return OUT_W'(v);
  endfunction

  function automatic distorted_t distort_point(input point_t p);
    longint     x, y, xx, yy, xy, r2, r4, x2, y2, pxy, rad, tx, ty;
    distorted_t res;
    x   = longint'(p.x);
    y   = longint'(p.y);
    xx  = x * x;
    yy  = y * y;
    xy  = x * y;
    r2  = clamp_mid(round_q(xx + yy));
    r4  = clamp_mid(round_q(r2 * r2));
    x2  = clamp_mid(round_q(xx));
    y2  = clamp_mid(round_q(yy));
    pxy = clamp_mid(round_q(xy));
    rad = clamp_mid(longint'(Q_ONE) + round_q(longint'(coef_k1) * r2)
                    + round_q(longint'(coef_k2) * r4));
    tx  = round_q(x * rad) + round_q(2 * longint'(coef_p1) * pxy)
          + round_q(longint'(coef_p2) * (r2 + 2 * x2));
    ty  = round_q(y * rad) + round_q(longint'(coef_p1) * (r2 + 2 * y2))
          + round_q(2 * longint'(coef_p2) * pxy);
    res.clip = 1'b0;
    res.dx   = clamp_out(tx, res.clip);
    res.dy   = clamp_out(ty, res.clip);
    return res;
  endfunction

  function automatic logic signed [IN_W-1:0] random_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return IN_W'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
      5, 6: return IN_W'($urandom);
      7: begin
        case ($urandom_range(0, 4))
          0: return IN_W'(Q_HI);
          1: return IN_W'(Q_LO);
          2: return '0;
          3: return IN_W'(1);
          default: return IN_W'(-1);
        endcase
      end
      default: return IN_W'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic logic signed [IN_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return IN_W'(Q_HI);
      1: return IN_W'(Q_LO);
      2: return '0;
      3, 4: return IN_W'(int'($urandom_range(0, 32768)) - 16384);
      5: return IN_W'(int'($urandom_range(0, 256)) - 128);
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic signed [IN_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      lrtd_pkg::REG_K1: coef_k1 = val;
      lrtd_pkg::REG_K2: coef_k2 = val;
      lrtd_pkg::REG_P1: coef_p1 = val;
      lrtd_pkg::REG_P2: coef_p2 = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_coefs(input logic signed [IN_W-1:0] k1, input logic signed [IN_W-1:0] k2,
                           input logic signed [IN_W-1:0] p1, input logic signed [IN_W-1:0] p2);
    write_reg(lrtd_pkg::REG_K1, k1);
    write_reg(lrtd_pkg::REG_K2, k2);
    write_reg(lrtd_pkg::REG_P1, p1);
    write_reg(lrtd_pkg::REG_P2, p2);
  endtask

  task automatic push_point(input int x, input int y);
    point_t p;
    p.x = IN_W'(x);
    p.y = IN_W'(y);
    pending_points.insert(pending_points.size(), p);
  endtask

  task automatic load_corner_points();
    push_point(0, 0);
    push_point(Q_HI, Q_HI);
    push_point(Q_LO, Q_LO);
    push_point(Q_HI, Q_LO);
    push_point(Q_LO, Q_HI);
    push_point(1, -1);
    push_point(-1, 1);
    push_point(Q_ONE, 0);
    push_point(0, -Q_ONE);
    push_point(Q_HI, 0);
    push_point(0, Q_LO);
    push_point(Q_ONE / 2, -Q_ONE / 2);
  endtask

  task automatic load_random_points(input int count);
    point_t p;
    repeat (count) begin
      p.x = random_coord();
      p.y = random_coord();
      pending_points.insert(pending_points.size(), p);
    end
  endtask

  // hold until every item is taken and every result is back, then drain
  task automatic wait_idle();
    while (pending_points.size() != 0 || start || expected_points.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      burst_left  = 0;
      gap_left    = 0;
    end else begin
      if (start && !busy) begin
        next_point.x = in_norm_x;
        next_point.y = in_norm_y;
        expected_points.insert(expected_points.size(), distort_point(next_point));
      end
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          gap_left--;
          start     <= 1'b0;
          in_norm_x <= IN_W'($urandom);
          in_norm_y <= IN_W'($urandom);
        end else if (pending_points.size() != 0) begin
          next_point = pending_points.pop_front();
          in_norm_x <= next_point.x;
          in_norm_y <= next_point.y;
          start     <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected item", longint'(out_dist_x), longint'(0));
      end else begin
        oldest_point = expected_points.pop_front();
        if (out_dist_x !== oldest_point.dx) begin
          report_mismatch("dist_x", longint'(out_dist_x), longint'(oldest_point.dx));
        end
        if (out_dist_y !== oldest_point.dy) begin
          report_mismatch("dist_y", longint'(out_dist_y), longint'(oldest_point.dy));
        end
        if (out_clipped !== oldest_point.clip) begin
          report_mismatch("clipped", longint'(out_clipped), longint'(oldest_point.clip));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lens_radial_tangential_distortion_unit regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    load_corner_points();
    wait_idle();

    set_coefs(IN_W'(Q_HI), IN_W'(Q_HI), IN_W'(Q_HI), IN_W'(Q_HI));
    for (int i = int'(lrtd_pkg::REG_P2) + 1; i < (1 << IDX_W); i++) begin
      write_reg(IDX_W'(i), IN_W'($urandom));
    end
    load_corner_points();
    wait_idle();

    set_coefs(IN_W'(Q_LO), IN_W'(Q_LO), IN_W'(Q_LO), IN_W'(Q_LO));
    load_random_points(240);
    wait_idle();

    set_coefs(IN_W'(-18350), IN_W'(4588), IN_W'(66), IN_W'(-33));
    load_random_points(240);
    wait_idle();

    repeat (6) begin
      set_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
      load_random_points(240);
      wait_idle();
    end

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("lens_radial_tangential_distortion_unit regression: pass");
    end else begin
      $display("lens_radial_tangential_distortion_unit regression: fail");
    end
    $finish;
  end

endmodule
